### rtl/spfds_pkg.sv
// Package for the smallest-prime-factor sieve and divisor-sum block.
// Holds state machine types and fixed field widths; depends on nothing.
package spfds_pkg;

    localparam int NUM_W = 16;
    localparam int SUM_W = 18;
    localparam int ACC_W = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_OUT_RD = 6'b000010,
        S_OUT_CK = 6'b000100,
        S_IN_RD  = 6'b001000,
        S_IN_WR  = 6'b010000,
        S_DONE   = 6'b100000
    } sieve_state_t;

    typedef enum logic [4:0] {
        Q_IDLE = 5'b00001,
        Q_LOOK = 5'b00010,
        Q_WAIT = 5'b00100,
        Q_STEP = 5'b01000,
        Q_FIN  = 5'b10000
    } query_state_t;

endpackage

### rtl/spf_sieve_divisor_sum.sv
// Top level: sieve-filled factor memory and the divisor-sum query engine.
// Uses spfds_pkg for state types and field widths.
// After reset a clearing pass over every entry and an odd-only sieve run;
// no request is taken until the sieve ends. A request then steps through
// each prime factor with a look step, a memory wait for odd cofactors and
// an update step, then a final step; one request is worked at a time.
// The result sits in an output register, so a new request may enter early.
module spf_sieve_divisor_sum #(
    parameter int TABLE_SIZE = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spfds_pkg::NUM_W-1:0] number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [spfds_pkg::SUM_W-1:0] proper_divisor_sum,
    output logic [spfds_pkg::NUM_W-1:0] smallest_factor,
    output logic                        is_prime
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam int IW = (AW + 1) / 2 + 2;
    localparam int JW = AW + 2;
    localparam int NW = spfds_pkg::NUM_W;
    localparam int XW = spfds_pkg::ACC_W;
    localparam int EW = 2 * NW;

    // Odd composites hold {smallest odd factor, cofactor}; rest are zero.
    logic [EW-1:0] mem [TABLE_SIZE];
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] raddr, waddr;
    logic [EW-1:0] wdata;
    logic          mem_we;

    spfds_pkg::sieve_state_t s_reg, s_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [IW-1:0] i_reg, i_next;
    logic [JW-1:0] j_reg, j_next;
    logic [NW-1:0] k_reg, k_next;
    logic [2*IW-1:0] i_sq;

    spfds_pkg::query_state_t q_reg, q_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] rest_reg, rest_next;
    logic [NW-1:0] p_reg, p_next;
    logic [NW-1:0] q_val_reg, q_val_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] term_reg, term_next;
    logic [XW-1:0] sum_reg, sum_next;
    logic [XW-1:0] prod_reg, prod_next;
    logic [NW-1:0] first_reg, first_next;
    logic          prime_reg, prime_next;
    logic          zero_reg, zero_next;
    logic          ready;

    logic                        ov_reg, ov_next;
    logic [spfds_pkg::SUM_W-1:0] ps_reg, ps_next;
    logic [NW-1:0]               sf_reg, sf_next;
    logic                        ip_reg, ip_next;

    logic [2*NW-1:0] term_mul;
    logic [2*XW-1:0] prod_mul;
    logic [2*XW-1:0] diff;

    assign ready = (s_reg == spfds_pkg::S_DONE);
    assign i_sq = i_reg * i_reg;
    assign term_mul = term_reg * p_reg;
    assign prod_mul = prod_reg * sum_reg;
    assign diff = prod_mul - (2*XW)'(n_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        s_next = s_reg;
        clr_next = clr_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        mem_we = 1'b0;
        waddr = AW'(clr_reg);
        wdata = '0;
        raddr = AW'(rest_reg);
        case (s_reg)
            spfds_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(TABLE_SIZE - 1))
                begin
                    s_next = spfds_pkg::S_OUT_RD;
                end
            end
            spfds_pkg::S_OUT_RD:
            begin
                raddr = AW'(i_reg);
                if (i_sq >= (2*IW)'(TABLE_SIZE))
                begin
                    s_next = spfds_pkg::S_DONE;
                end
                else
                begin
                    s_next = spfds_pkg::S_OUT_CK;
                end
            end
            spfds_pkg::S_OUT_CK:
            begin
                if (rdata_reg == '0)
                begin
                    j_next = JW'(i_sq);
                    k_next = NW'(i_reg);
                    s_next = spfds_pkg::S_IN_RD;
                end
                else
                begin
                    i_next = i_reg + IW'(2);
                    s_next = spfds_pkg::S_OUT_RD;
                end
            end
            spfds_pkg::S_IN_RD:
            begin
                raddr = AW'(j_reg);
                if (j_reg >= JW'(TABLE_SIZE))
                begin
                    i_next = i_reg + IW'(2);
                    s_next = spfds_pkg::S_OUT_RD;
                end
                else
                begin
                    s_next = spfds_pkg::S_IN_WR;
                end
            end
            spfds_pkg::S_IN_WR:
            begin
                waddr = AW'(j_reg);
                wdata = {NW'(i_reg), k_reg};
                mem_we = (rdata_reg == '0);
                j_next = j_reg + JW'({i_reg, 1'b0});
                k_next = k_reg + NW'(2);
                s_next = spfds_pkg::S_IN_RD;
            end
            spfds_pkg::S_DONE:
            begin
            end
            default:
            begin
                s_next = spfds_pkg::S_CLEAR;
            end
        endcase
    end

    assign in_stall = !ready || (q_reg != spfds_pkg::Q_IDLE);

    always_comb
    begin
        q_next = q_reg;
        n_next = n_reg;
        rest_next = rest_reg;
        p_next = p_reg;
        q_val_next = q_val_reg;
        cur_next = cur_reg;
        term_next = term_reg;
        sum_next = sum_reg;
        prod_next = prod_reg;
        first_next = first_reg;
        prime_next = prime_reg;
        zero_next = zero_reg;
        ov_next = ov_reg && out_stall;
        ps_next = ps_reg;
        sf_next = sf_reg;
        ip_next = ip_reg;
        case (q_reg)
            spfds_pkg::Q_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    n_next = number;
                    rest_next = number;
                    cur_next = '0;
                    term_next = NW'(1);
                    sum_next = XW'(1);
                    prod_next = XW'(1);
                    first_next = '0;
                    prime_next = 1'b0;
                    zero_next = (number < NW'(2)) ||
                                (32'(number) >= 32'(TABLE_SIZE));
                    q_next = zero_next ? spfds_pkg::Q_FIN : spfds_pkg::Q_LOOK;
                end
            end
            spfds_pkg::Q_LOOK:
            begin
                if (rest_reg == NW'(1))
                begin
                    q_next = spfds_pkg::Q_FIN;
                end
                else if (!rest_reg[0])
                begin
                    p_next = NW'(2);
                    q_val_next = rest_reg >> 1;
                    q_next = spfds_pkg::Q_STEP;
                end
                else
                begin
                    q_next = spfds_pkg::Q_WAIT;
                end
            end
            spfds_pkg::Q_WAIT:
            begin
                if (rdata_reg == '0)
                begin
                    p_next = rest_reg;
                    q_val_next = NW'(1);
                end
                else
                begin
                    p_next = rdata_reg[EW-1:NW];
                    q_val_next = rdata_reg[NW-1:0];
                end
                q_next = spfds_pkg::Q_STEP;
            end
            spfds_pkg::Q_STEP:
            begin
                if (cur_reg == '0)
                begin
                    first_next = p_reg;
                    prime_next = (q_val_reg == NW'(1));
                end
                if (p_reg == cur_reg)
                begin
                    term_next = term_mul[NW-1:0];
                    sum_next = sum_reg + XW'(term_mul[NW-1:0]);
                end
                else
                begin
                    prod_next = prod_mul[XW-1:0];
                    cur_next = p_reg;
                    term_next = p_reg;
                    sum_next = XW'(p_reg) + XW'(1);
                end
                rest_next = q_val_reg;
                q_next = spfds_pkg::Q_LOOK;
            end
            spfds_pkg::Q_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    if (zero_reg)
                    begin
                        ps_next = '0;
                        sf_next = '0;
                        ip_next = 1'b0;
                    end
                    else
                    begin
                        ps_next = (diff > (2*XW)'(spfds_pkg::SUM_MAX)) ?
                                  spfds_pkg::SUM_MAX : diff[spfds_pkg::SUM_W-1:0];
                        sf_next = first_reg;
                        ip_next = prime_reg;
                    end
                    q_next = spfds_pkg::Q_IDLE;
                end
            end
            default:
            begin
                q_next = spfds_pkg::Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= spfds_pkg::S_CLEAR;
            clr_reg <= '0;
            i_reg <= IW'(3);
            q_reg <= spfds_pkg::Q_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            s_reg <= s_next;
            clr_reg <= clr_next;
            i_reg <= i_next;
            q_reg <= q_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;
        k_reg <= k_next;
        n_reg <= n_next;
        rest_reg <= rest_next;
        p_reg <= p_next;
        q_val_reg <= q_val_next;
        cur_reg <= cur_next;
        term_reg <= term_next;
        sum_reg <= sum_next;
        prod_reg <= prod_next;
        first_reg <= first_next;
        prime_reg <= prime_next;
        zero_reg <= zero_next;
        ps_reg <= ps_next;
        sf_reg <= sf_next;
        ip_reg <= ip_next;
    end

    assign out_valid = ov_reg;
    assign proper_divisor_sum = ps_reg;
    assign smallest_factor = sf_reg;
    assign is_prime = ip_reg;

    a_no_request_before_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> ready)
        else $error("request taken before the sieve finished");

    a_no_write_after_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !ready)
        else $error("factor memory written after the sieve finished");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(q_reg == spfds_pkg::Q_FIN))
        else $error("result appeared outside the final step");

    a_prime_sum_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_prime) |-> (proper_divisor_sum == spfds_pkg::SUM_W'(1)))
        else $error("prime with proper divisor sum other than one");

endmodule
